FILE: src/flag_pkg.sv
// Shared widths, register indexes and types of the filter layout address generator.
`default_nettype none

package flag_pkg;

    localparam int FC_W      = 12;  // filter_count register
    localparam int CC_W      = 12;  // channel_count register
    localparam int K_W       = 5;   // kernel_height and kernel_width registers
    localparam int FI_W      = 11;  // filter counter
    localparam int PADC_W    = 13;  // padded channel count, up to 4096
    localparam int KK_W      = 10;  // rows times columns
    localparam int FRAME_W   = 23;  // padded channels times rows times columns
    localparam int PADF_W    = 13;  // padded filter count
    localparam int NUMER_W   = 13;  // numerator of the filter round-up
    localparam int ADDR_W    = 30;
    localparam int TOTAL_W   = 31;
    localparam int WORD_W    = 32;
    localparam int PADDR_W   = 4;

    localparam int MAX_FILTERS = 2048;

    // Cycles the geometry pipeline needs to follow a register change.
    localparam int SETTLE_W               = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

    typedef enum logic [1:0] {
        REG_FILTER_COUNT  = 2'd0,
        REG_CHANNEL_COUNT = 2'd1,
        REG_KERNEL_HEIGHT = 2'd2,
        REG_KERNEL_WIDTH  = 2'd3
    } reg_index_t;

    // Derived layout sizes, handed from the geometry unit to the address logic.
    typedef struct packed {
        logic [PADC_W-1:0]  pad_chan;
        logic [FRAME_W-1:0] frame;
        logic [TOTAL_W-1:0] total;
    } geom_t;

endpackage

`default_nettype wire

FILE: src/flag_geometry.sv
// Pipelined computation of the padded channel stride, filter frame size and buffer size.
`default_nettype none

module flag_geometry
    import flag_pkg::*;
#(
    parameter int FILTER_LANES = 1024
)
(
    input  wire logic            clk,
    input  wire logic [FC_W-1:0] filter_count,
    input  wire logic [CC_W-1:0] channel_count,
    input  wire logic [K_W-1:0]  kernel_height,
    input  wire logic [K_W-1:0]  kernel_width,
    output geom_t                geom
);

    // Lane groups for each channel padding unit.
    localparam int G16  = FILTER_LANES / 16;
    localparam int G32  = FILTER_LANES / 32;
    localparam int G64  = FILTER_LANES / 64;
    localparam int G128 = FILTER_LANES / 128;
    localparam int GW   = $clog2(G16 + 1);

    // Exact division of a NUMER_W-bit value by a group size through a reciprocal.
    localparam int L  = $clog2(G16);
    localparam int SH = NUMER_W + L;
    localparam int MW = SH + 1;
    localparam logic [MW-1:0] M16  = MW'(((64'd1 << SH) + 64'(G16)  - 64'd1) / 64'(G16));
    localparam logic [MW-1:0] M32  = MW'(((64'd1 << SH) + 64'(G32)  - 64'd1) / 64'(G32));
    localparam logic [MW-1:0] M64  = MW'(((64'd1 << SH) + 64'(G64)  - 64'd1) / 64'(G64));
    localparam logic [MW-1:0] M128 = MW'(((64'd1 << SH) + 64'(G128) - 64'd1) / 64'(G128));

    logic [PADC_W-1:0]        pad_chan_c;
    logic [GW-1:0]            group_c;
    logic [MW-1:0]            recip_c;
    logic [NUMER_W-1:0]       numer_c;

    logic [PADC_W-1:0]        pad_chan1_reg;
    logic [KK_W-1:0]          kk_reg;
    logic [NUMER_W+MW-1:0]    qprod_reg;
    logic [GW-1:0]            group_reg;

    logic [PADF_W-1:0]        quot_c;
    logic [PADF_W+GW-1:0]     padf_prod_c;
    logic [PADC_W+KK_W-1:0]   frame_prod_c;

    logic [PADC_W-1:0]        pad_chan2_reg;
    logic [FRAME_W-1:0]       frame_reg;
    logic [PADF_W-1:0]        pad_filt_reg;

    logic [PADF_W+FRAME_W-1:0] total_prod_c;
    logic [TOTAL_W-1:0]       total_reg;

    always_comb
    begin
        priority if (channel_count <= CC_W'(16))
        begin
            pad_chan_c = PADC_W'(16);
            group_c    = GW'(G16);
            recip_c    = M16;
        end
        else if (channel_count <= CC_W'(32))
        begin
            pad_chan_c = PADC_W'(32);
            group_c    = GW'(G32);
            recip_c    = M32;
        end
        else if (channel_count <= CC_W'(64))
        begin
            pad_chan_c = PADC_W'(64);
            group_c    = GW'(G64);
            recip_c    = M64;
        end
        else
        begin
            pad_chan_c = (PADC_W'(channel_count) + PADC_W'(127)) & ~PADC_W'(127);
            group_c    = GW'(G128);
            recip_c    = M128;
        end
        numer_c = NUMER_W'(filter_count) + NUMER_W'(group_c) - NUMER_W'(1);
    end

    assign quot_c       = PADF_W'(qprod_reg >> SH);
    assign padf_prod_c  = quot_c * group_reg;
    assign frame_prod_c = pad_chan1_reg * kk_reg;
    assign total_prod_c = pad_filt_reg * frame_reg;

    always_ff @(posedge clk)
    begin
        pad_chan1_reg <= pad_chan_c;
        kk_reg        <= KK_W'(kernel_height) * KK_W'(kernel_width);
        qprod_reg     <= (NUMER_W+MW)'(numer_c) * (NUMER_W+MW)'(recip_c);
        group_reg     <= group_c;

        pad_chan2_reg <= pad_chan1_reg;
        frame_reg     <= FRAME_W'(frame_prod_c);
        pad_filt_reg  <= PADF_W'(padf_prod_c);

        total_reg     <= TOTAL_W'(total_prod_c);
    end

    assign geom.pad_chan = pad_chan2_reg;
    assign geom.frame    = frame_reg;
    assign geom.total    = total_reg;

endmodule

`default_nettype wire

FILE: src/filter_layout_address_generator.sv
// Top level: filter weight reorder address generator with APB register port.
`default_nettype none

//  Channel   Signals                                       Direction
//  weights   in_valid, in_ready, weight_bits               in
//  results   out_valid, out_ready, dest_address,           out
//            weight_out, last_weight, padded_total
//  config    psel, penable, pwrite, paddr, pwdata,         in/out
//            prdata, pready
//
// One weight is taken per cycle while in_ready is high; its result is registered in
// the output register, or in a skid register while the output stalls, so one more
// transfer is taken while the consumer holds off. The address comes from running
// counters and strided base registers, so only one three-input add stands in the
// path. A register write restarts the set and holds in_ready low while the
// three-stage geometry pipeline, with a multiplier in each stage, follows; reset
// does the same.

module filter_layout_address_generator
    import flag_pkg::*;
#(
    parameter int FILTER_LANES = 1024,
    parameter int MAX_CHANNELS = 2048,
    parameter int MAX_KERNEL   = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [WORD_W-1:0]  weight_bits,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [ADDR_W-1:0]       dest_address,
    output logic [WORD_W-1:0]       weight_out,
    output logic                    last_weight,
    output logic [TOTAL_W-1:0]      padded_total,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [WORD_W-1:0]  weight;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } result_t;

    // Configuration registers, held already clamped to their legal ranges.
    logic [FC_W-1:0]     filter_count_reg;
    logic [CC_W-1:0]     channel_count_reg;
    logic [K_W-1:0]      kernel_height_reg;
    logic [K_W-1:0]      kernel_width_reg;

    logic [SETTLE_W-1:0] settle_reg;

    // Position of the next weight and the address bases that go with it.
    logic [FI_W-1:0]     filt_reg;
    logic [CC_W-1:0]     chan_reg;
    logic [K_W-1:0]      row_reg;
    logic [K_W-1:0]      col_reg;
    logic [ADDR_W-1:0]   filt_base_reg;
    logic [FRAME_W-1:0]  pos_base_reg;

    logic                out_valid_reg;
    result_t             out_reg;
    logic                skid_valid_reg;
    result_t             skid_reg;

    geom_t               geom;
    reg_index_t          reg_index;
    logic                cfg_write;
    logic                accept;
    logic                take;
    logic                col_end;
    logic                row_end;
    logic                chan_end;
    logic                filt_end;
    logic                last_c;
    result_t             result_c;

    function automatic logic [FC_W-1:0] clamp_filters(input logic [FC_W-1:0] v);
        logic [FC_W-1:0] r;
        if (v == '0)
            r = FC_W'(1);
        else if (v > FC_W'(MAX_FILTERS))
            r = FC_W'(MAX_FILTERS);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [CC_W-1:0] clamp_channels(input logic [CC_W-1:0] v);
        logic [CC_W-1:0] r;
        if (v == '0)
            r = CC_W'(1);
        else if ({1'b0, v} > (CC_W+1)'(MAX_CHANNELS))
            r = CC_W'(MAX_CHANNELS);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [K_W-1:0] clamp_kernel(input logic [K_W-1:0] v);
        logic [K_W-1:0] r;
        if (v == '0)
            r = K_W'(1);
        else if ({1'b0, v} > (K_W+1)'(MAX_KERNEL))
            r = K_W'(MAX_KERNEL);
        else
            r = v;
        return r;
    endfunction

    flag_geometry #(
        .FILTER_LANES (FILTER_LANES)
    ) u_geometry (
        .clk           (clk),
        .filter_count  (filter_count_reg),
        .channel_count (channel_count_reg),
        .kernel_height (kernel_height_reg),
        .kernel_width  (kernel_width_reg),
        .geom          (geom)
    );

    // Register port. Every address decodes to one of the four registers.
    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_index)
            REG_FILTER_COUNT:  prdata = 32'(filter_count_reg);
            REG_CHANNEL_COUNT: prdata = 32'(channel_count_reg);
            REG_KERNEL_HEIGHT: prdata = 32'(kernel_height_reg);
            REG_KERNEL_WIDTH:  prdata = 32'(kernel_width_reg);
            default:           prdata = '0;
        endcase
    end

    // Handshakes. The skid register absorbs one transfer while the output stalls.
    assign in_ready = !skid_valid_reg && (settle_reg == '0);
    assign accept   = in_valid && in_ready;
    assign take     = out_valid_reg && out_ready;

    // End-of-dimension flags for the current position.
    assign col_end  = ((K_W+1)'(col_reg) + (K_W+1)'(1)) >= (K_W+1)'(kernel_width_reg);
    assign row_end  = ((K_W+1)'(row_reg) + (K_W+1)'(1)) >= (K_W+1)'(kernel_height_reg);
    assign chan_end = ((CC_W+1)'(chan_reg) + (CC_W+1)'(1)) >= (CC_W+1)'(channel_count_reg);
    assign filt_end = ((FC_W+1)'(filt_reg) + (FC_W+1)'(1)) >= (FC_W+1)'(filter_count_reg);
    assign last_c   = col_end && row_end && chan_end && filt_end;

    always_comb
    begin
        result_c.addr   = filt_base_reg + ADDR_W'(pos_base_reg) + ADDR_W'(chan_reg);
        result_c.weight = weight_bits;
        result_c.last   = last_c;
        result_c.total  = last_c ? geom.total : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_count_reg  <= FC_W'(1);
            channel_count_reg <= CC_W'(1);
            kernel_height_reg <= K_W'(1);
            kernel_width_reg  <= K_W'(1);
            settle_reg        <= SETTLE_CYCLES;
            filt_reg          <= '0;
            chan_reg          <= '0;
            row_reg           <= '0;
            col_reg           <= '0;
            filt_base_reg     <= '0;
            pos_base_reg      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_FILTER_COUNT:  filter_count_reg  <= clamp_filters(pwdata[FC_W-1:0]);
                REG_CHANNEL_COUNT: channel_count_reg <= clamp_channels(pwdata[CC_W-1:0]);
                REG_KERNEL_HEIGHT: kernel_height_reg <= clamp_kernel(pwdata[K_W-1:0]);
                REG_KERNEL_WIDTH:  kernel_width_reg  <= clamp_kernel(pwdata[K_W-1:0]);
                default:           filter_count_reg  <= filter_count_reg;
            endcase
            // Any write starts a new set.
            settle_reg    <= SETTLE_CYCLES;
            filt_reg      <= '0;
            chan_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            filt_base_reg <= '0;
            pos_base_reg  <= '0;
        end
        else
        begin
            if (settle_reg != '0)
                settle_reg <= settle_reg - SETTLE_W'(1);

            if (accept)
            begin
                priority if (last_c)
                begin
                    filt_reg      <= '0;
                    chan_reg      <= '0;
                    row_reg       <= '0;
                    col_reg       <= '0;
                    filt_base_reg <= '0;
                    pos_base_reg  <= '0;
                end
                else if (!col_end)
                begin
                    col_reg      <= col_reg + K_W'(1);
                    pos_base_reg <= pos_base_reg + FRAME_W'(geom.pad_chan);
                end
                else if (!row_end)
                begin
                    // Row and column together step by one channel stride.
                    col_reg      <= '0;
                    row_reg      <= row_reg + K_W'(1);
                    pos_base_reg <= pos_base_reg + FRAME_W'(geom.pad_chan);
                end
                else if (!chan_end)
                begin
                    col_reg      <= '0;
                    row_reg      <= '0;
                    pos_base_reg <= '0;
                    chan_reg     <= chan_reg + CC_W'(1);
                end
                else
                begin
                    col_reg       <= '0;
                    row_reg       <= '0;
                    pos_base_reg  <= '0;
                    chan_reg      <= '0;
                    filt_reg      <= filt_reg + FI_W'(1);
                    filt_base_reg <= filt_base_reg + ADDR_W'(geom.frame);
                end
            end
        end
    end

    // Output register and skid register: valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output register and skid register: payload.
    always_ff @(posedge clk)
    begin
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result_c;
        end
        else if (accept)
        begin
            skid_reg <= result_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_address = out_reg.addr;
    assign weight_out   = out_reg.weight;
    assign last_weight  = out_reg.last;
    assign padded_total = out_reg.total;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the filter layout address generator.

module tb;
    import flag_pkg::*;

    // Block parameters; the instance below uses the same values.
    localparam int FILTER_LANES = 1024;
    localparam int MAX_CHANNELS = 2048;
    localparam int MAX_KERNEL   = 16;

    // Cycles with no transfer of any kind before the run is declared hung.
    // The longest deliberate hold-off is far shorter than this, so this is ample.
    localparam int STALL_LIMIT  = 3000;

    // Cycles allowed after the last result for anything stray to show up.
    localparam int TAIL_CYCLES  = 12;

    // Expected content of one result transfer.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [WORD_W-1:0]  word;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } placement_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [WORD_W-1:0]  weight_bits  = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [ADDR_W-1:0]  dest_address;
    logic [WORD_W-1:0]  weight_out;
    logic               last_weight;
    logic [TOTAL_W-1:0] padded_total;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;

    filter_layout_address_generator #(
        .FILTER_LANES (FILTER_LANES),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_KERNEL   (MAX_KERNEL)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .weight_bits  (weight_bits),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dest_address (dest_address),
        .weight_out   (weight_out),
        .last_weight  (last_weight),
        .padded_total (padded_total),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Our own copy of the layout registers, as the block uses them after clamping.
    longint unsigned cfg_filters  = 1;
    longint unsigned cfg_channels = 1;
    longint unsigned cfg_rows     = 1;
    longint unsigned cfg_cols     = 1;

    // Position of the next weight within the current set.
    longint unsigned at_filter = 0;
    longint unsigned at_chan   = 0;
    longint unsigned at_row    = 0;
    longint unsigned at_col    = 0;

    // Results still owed by the block, oldest first.
    placement_t pending_placements[$];

    int mismatch_count    = 0;
    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int hold_results_for  = 0;

    // A register write clamps the value: zero reads as one, anything above the
    // maximum reads as the maximum.
    function automatic longint unsigned clamp_field(input longint unsigned v,
                                                    input longint unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint unsigned set_length();
        return cfg_filters * cfg_channels * cfg_rows * cfg_cols;
    endfunction

    // Works out where one weight lands in the padded filter-row-column-channel
    // buffer and steps the position on to the next weight.
    function automatic placement_t place_weight(input logic [WORD_W-1:0] w);
        longint unsigned unit;
        longint unsigned pad_c;
        longint unsigned group;
        longint unsigned pad_f;
        longint unsigned addr;
        longint unsigned total;
        bit              closes_set;
        placement_t      p;

        // Channel stride: 16, 32 or 64 for small counts, else a multiple of 128.
        if (cfg_channels <= 16)
            unit = 16;
        else if (cfg_channels <= 32)
            unit = 32;
        else if (cfg_channels <= 64)
            unit = 64;
        else
            unit = 128;
        pad_c = ((cfg_channels + unit - 1) / unit) * unit;

        // The filter count is padded to the number of filters sharing the lanes.
        group = FILTER_LANES / unit;
        if (group == 0)
            group = 1;
        pad_f = ((cfg_filters + group - 1) / group) * group;

        addr  = at_filter * pad_c * cfg_rows * cfg_cols
              + (at_row * cfg_cols + at_col) * pad_c
              + at_chan;
        total = pad_f * pad_c * cfg_rows * cfg_cols;

        closes_set = (at_filter + 1 >= cfg_filters) && (at_chan + 1 >= cfg_channels) &&
                     (at_row + 1 >= cfg_rows) && (at_col + 1 >= cfg_cols);

        p.addr  = addr[ADDR_W-1:0];
        p.word  = w;
        p.last  = closes_set;
        p.total = closes_set ? total[TOTAL_W-1:0] : '0;

        // Column runs fastest, then row, then channel, then filter.
        if (closes_set)
        begin
            at_filter = 0;
            at_chan   = 0;
            at_row    = 0;
            at_col    = 0;
        end
        else if (at_col + 1 < cfg_cols)
            at_col++;
        else
        begin
            at_col = 0;
            if (at_row + 1 < cfg_rows)
                at_row++;
            else
            begin
                at_row = 0;
                if (at_chan + 1 < cfg_channels)
                    at_chan++;
                else
                begin
                    at_chan = 0;
                    at_filter++;
                end
            end
        end
        return p;
    endfunction

    // Offers one weight, after a random gap, and waits for the transfer. The
    // expectation is recorded at the edge that accepts the weight. Valid is only
    // lowered inside a gap, so back-to-back weights keep it high throughout.
    task automatic send_weight(input logic [WORD_W-1:0] w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        weight_bits <= w;
        do
            @(posedge clk);
        while (!in_ready);
        pending_placements.push_back(place_weight(w));
    endtask

    // Withdraws the sender and waits until every owed result has been taken.
    // At least one edge passes, so valid is never raised in the step that lowers it.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_placements.size() != 0);
    endtask

    // One APB write: setup cycle, access cycle, then a cycle with the port idle
    // so that a following write never touches psel twice in the same step.
    task automatic program_register(input reg_index_t idx, input logic [31:0] raw);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= raw;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_FILTER_COUNT:  cfg_filters  = clamp_field(raw[FC_W-1:0], MAX_FILTERS);
            REG_CHANNEL_COUNT: cfg_channels = clamp_field(raw[CC_W-1:0], MAX_CHANNELS);
            REG_KERNEL_HEIGHT: cfg_rows     = clamp_field(raw[K_W-1:0], MAX_KERNEL);
            REG_KERNEL_WIDTH:  cfg_cols     = clamp_field(raw[K_W-1:0], MAX_KERNEL);
            default: ;
        endcase
        // Any write to a layout register starts a fresh set.
        at_filter = 0;
        at_chan   = 0;
        at_row    = 0;
        at_col    = 0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Picks a raw register value that the block reads as v. Values at the ends
    // are sometimes given in their out-of-range form, and bits above the field
    // are sometimes filled with rubbish, which the block must ignore.
    function automatic logic [31:0] encode_field(input longint unsigned v, input int width,
                                                 input longint unsigned hi);
        logic [31:0] raw;
        raw = v[31:0];
        if (v == 1 && $urandom_range(0, 3) == 0)
            raw = '0;
        else if (v == hi && $urandom_range(0, 2) == 0)
            raw = $urandom_range(hi, (1 << width) - 1);
        if ($urandom_range(0, 3) == 0)
            raw = raw | ($urandom() << width);
        return raw;
    endfunction

    // Writes the registers that change, plus a random selection of the rest;
    // at least one write always happens, so the set restarts.
    task automatic apply_layout(input longint unsigned f, input longint unsigned c,
                                input longint unsigned h, input longint unsigned w);
        bit wrote;
        wrote = 1'b0;
        if (f != cfg_filters || $urandom_range(0, 2) == 0)
        begin
            program_register(REG_FILTER_COUNT, encode_field(f, FC_W, MAX_FILTERS));
            wrote = 1'b1;
        end
        if (c != cfg_channels || $urandom_range(0, 2) == 0)
        begin
            program_register(REG_CHANNEL_COUNT, encode_field(c, CC_W, MAX_CHANNELS));
            wrote = 1'b1;
        end
        if (h != cfg_rows || $urandom_range(0, 2) == 0)
        begin
            program_register(REG_KERNEL_HEIGHT, encode_field(h, K_W, MAX_KERNEL));
            wrote = 1'b1;
        end
        if (w != cfg_cols || $urandom_range(0, 2) == 0)
        begin
            program_register(REG_KERNEL_WIDTH, encode_field(w, K_W, MAX_KERNEL));
            wrote = 1'b1;
        end
        if (!wrote)
            program_register(REG_FILTER_COUNT, encode_field(f, FC_W, MAX_FILTERS));
    endtask

    function automatic logic [WORD_W-1:0] random_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // After reset every register reads as one: each weight closes its own set.
    task automatic test_reset_defaults();
        send_idle_pct = 30;
        recv_idle_pct = 30;
        send_weight('0);
        send_weight('1);
        send_weight(32'hAAAA_AAAA);
        send_weight(32'h5555_5555);
        wait_drained();
    endtask

    // Out-of-range values, rubbish above the fields, and restarts part-way
    // through a set, all with the widest channel stride the block allows.
    task automatic test_register_limits();
        program_register(REG_FILTER_COUNT, 32'h0);
        program_register(REG_CHANNEL_COUNT, 32'h0000_0FFF);
        program_register(REG_KERNEL_HEIGHT, 32'h0000_001F);
        program_register(REG_KERNEL_WIDTH, 32'h0);
        repeat (4) send_weight(random_weight());
        wait_drained();
        program_register(REG_KERNEL_WIDTH, 32'hFFFF_FFE5);
        repeat (3) send_weight(random_weight());
        wait_drained();
        program_register(REG_FILTER_COUNT, 32'h8000_1FFF);
        program_register(REG_KERNEL_HEIGHT, 32'h7FFF_FFF0);
        repeat (3) send_weight(random_weight());
        wait_drained();
    endtask

    // A complete small set, so the last marker and the padded size appear,
    // then one more weight to show the wrap into a new set.
    task automatic test_small_set();
        program_register(REG_FILTER_COUNT, 32'd2);
        program_register(REG_CHANNEL_COUNT, 32'd2);
        program_register(REG_KERNEL_HEIGHT, 32'd1);
        program_register(REG_KERNEL_WIDTH, 32'd2);
        repeat (9) send_weight(random_weight());
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering,
    // so the block fills and stalls its input. The sender then pauses until
    // every result is in before it finishes the set.
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_register(REG_FILTER_COUNT, 32'd3);
        program_register(REG_CHANNEL_COUNT, 32'd20);
        program_register(REG_KERNEL_HEIGHT, 32'd2);
        program_register(REG_KERNEL_WIDTH, 32'd2);
        hold_results_for = 300;
        repeat (40) send_weight(random_weight());
        wait_drained();
        repeat (set_length() - 40) send_weight(random_weight());
        wait_drained();
    endtask

    // Random layouts with random weights. Most phases send one or two whole
    // sets; some break off part-way, and a few use large layouts of which only
    // the opening weights are sent.
    task automatic test_random_sets(input int send_pct, input int recv_pct, input int quota);
        longint unsigned f;
        longint unsigned c;
        longint unsigned h;
        longint unsigned w;
        longint unsigned count;
        bit              wide;
        int              sent;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < quota)
        begin
            wide = ($urandom_range(0, 9) == 0);
            do
            begin
                f = wide ? $urandom_range(1, MAX_FILTERS) : $urandom_range(1, 6);
                case ($urandom_range(0, 3))
                    0:       c = $urandom_range(1, 16);
                    1:       c = $urandom_range(17, 32);
                    2:       c = $urandom_range(33, 64);
                    default: c = wide ? $urandom_range(65, MAX_CHANNELS)
                                      : $urandom_range(65, 150);
                endcase
                h = wide ? $urandom_range(1, MAX_KERNEL) : $urandom_range(1, 3);
                w = wide ? $urandom_range(1, MAX_KERNEL) : $urandom_range(1, 3);
            end
            while (!wide && f * c * h * w > 360);
            apply_layout(f, c, h, w);
            if (wide)
                count = $urandom_range(1, 30);
            else if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, set_length());
            else
                count = set_length() * $urandom_range(1, 2);
            repeat (count) send_weight(random_weight());
            sent += count;
            wait_drained();
        end
    endtask

    // Receiver: takes results at random, or refuses them outright for a whole
    // hold-off stretch that it counts down itself.
    always @(posedge clk)
    begin : result_sink
        int hold_left;
        if (hold_results_for > 0)
        begin
            hold_left        = hold_results_for;
            hold_results_for = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Every result transfer is checked against the oldest expectation, field by field.
    always @(posedge clk)
    begin : result_check
        placement_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_placements.size() == 0)
            begin
                $error("result transfer with nothing expected: dest_address %0d weight_out %h",
                       dest_address, weight_out);
                mismatch_count++;
            end
            else
            begin
                exp = pending_placements.pop_front();
                if (dest_address !== exp.addr)
                begin
                    $error("dest_address: expected %0d, got %0d", exp.addr, dest_address);
                    mismatch_count++;
                end
                if (weight_out !== exp.word)
                begin
                    $error("weight_out: expected %h, got %h", exp.word, weight_out);
                    mismatch_count++;
                end
                if (last_weight !== exp.last)
                begin
                    $error("last_weight: expected %0b, got %0b", exp.last, last_weight);
                    mismatch_count++;
                end
                if (padded_total !== exp.total)
                begin
                    $error("padded_total: expected %0d, got %0d", exp.total, padded_total);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: any transfer on any port resets the count of quiet cycles.
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        // Reset is held first; the block then settles its geometry before it takes
        // the first transfer.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_limits();
        test_small_set();
        test_result_backpressure();

        // Sender mostly busy with a slow receiver, then the reverse, then flat out.
        test_random_sets(18, 82, 450);
        test_random_sets(82, 18, 450);
        test_random_sets(0, 0, 450);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
